// File: hw/rtl/stid_pkg.sv
// ----------------------------------------------------------------------------
// stid_pkg
// Shared types and constants for the sorted table insert/delete block.
// ----------------------------------------------------------------------------
`default_nettype none

package stid_pkg;

    // Table geometry
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    // Field widths fixed by the request/result format
    localparam int IN_VALUE_BITS = 32;
    localparam int OUT_CNT_BITS  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef logic signed [VALUE_BITS-1:0] t_key;

    // Request and result payloads
    typedef struct packed {
        t_mode                     mode;
        logic signed [IN_VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic                    found;
        logic [OUT_CNT_BITS-1:0] count;
    } t_rsp;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic ins;
        logic del;
        t_key key;
    } t_cell_ctl;

    // Reduce a 32-bit signed operand to the table's key width
    function automatic t_key to_key(input logic signed [IN_VALUE_BITS-1:0] value);
        logic signed [63:0] ext;
        ext = 64'(value);
        return ext[VALUE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stid_cell.sv
// ----------------------------------------------------------------------------
// stid_cell
// One slot of the sorted row: holds one key, compares it against the
// broadcast key and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module stid_cell (
    input  wire logic               i_clk,
    input  wire stid_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_valid,      // slot index below count
    input  wire logic               i_found,      // some slot holds the broadcast key
    input  wire stid_pkg::t_key     i_left_entry,
    input  wire logic               i_left_le,    // left slot holds key <= broadcast
    input  wire logic               i_left_lt,    // left slot holds key <  broadcast
    input  wire stid_pkg::t_key     i_right_entry,
    output stid_pkg::t_key          o_entry,
    output logic                    o_le,
    output logic                    o_lt,
    output logic                    o_hit         // first equal slot of the row
);
    import stid_pkg::*;

    t_key r_entry;
    t_key n_entry;
    logic w_eq;

    // Broadcast compare, masked by occupancy
    always_comb begin
        o_le  = i_valid && (r_entry <= i_ctl.key);
        o_lt  = i_valid && (r_entry <  i_ctl.key);
        w_eq  = i_valid && (r_entry == i_ctl.key);
        o_hit = w_eq && i_left_lt;
    end

    // Insert shifts right past the last entry <= key; delete shifts left
    // from the first entry not below key, only when the key is held.
    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins) begin
            if (!o_le) begin
                n_entry = i_left_le ? i_ctl.key : i_left_entry;
            end
        end else if (i_ctl.del && i_found) begin
            if (!o_lt) begin
                n_entry = i_right_entry;
            end
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_table_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_delete
// Ascending table of signed keys with insert, delete, lookup and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req (mode, value) with i_start; the request is
//   taken at a rising edge where i_start is high and o_busy is low. o_busy
//   stays low, so one request can be issued every cycle.
//   Result channel: o_done pulses for one cycle with o_rsp (status, found,
//   count) in the cycle after the request is taken. The receiver cannot stall;
//   it must capture the result in that cycle.
//   Throughput: one request per cycle. Each request is finished in the cycle
//   it is taken: every cell of the row compares its key against the
//   broadcast key, the one-hot first-match flags are ORed, and the cells past
//   the insert or delete point shift toward their neighbors at the same edge.
//   Reset (i_rst_n low, synchronous): count returns to zero and no result is
//   pending; the key storage is not cleared, slots at or above the count
//   are ignored.
//   Full insert is dropped with full status; a missing delete or lookup
//   reports not found. Equal keys on insert go after the existing ones.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_delete (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire stid_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_done,
    output stid_pkg::t_rsp     o_rsp
);
    import stid_pkg::*;

    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_done;
    t_rsp                r_rsp;
    t_rsp                n_rsp;

    logic      w_accept;
    logic      w_full;
    logic      w_found;
    t_cell_ctl w_ctl;

    t_key              w_entry [CAPACITY];
    t_key              w_left_entry [CAPACITY];
    t_key              w_right_entry [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_le;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_left_le;
    logic [CAPACITY-1:0] w_left_lt;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count >= CNT_BITS'(CAPACITY));
    assign w_found  = |w_hit;

    // Broadcast control to the row; delete is gated in each cell by the OR of all hits
    always_comb begin
        w_ctl.key = to_key(i_req.value);
        w_ctl.ins = w_accept && (i_req.mode == MODE_INSERT) && !w_full;
        w_ctl.del = w_accept && (i_req.mode == MODE_DELETE);
    end

    // Row of cells with neighbor links
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = (CNT_BITS'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left_entry[g] = w_ctl.key;
            assign w_left_le[g]    = 1'b1;
            assign w_left_lt[g]    = 1'b1;
        end else begin : g_mid
            assign w_left_entry[g] = w_entry[g-1];
            assign w_left_le[g]    = w_le[g-1];
            assign w_left_lt[g]    = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_entry[g] = w_entry[g];
        end else begin : g_body
            assign w_right_entry[g] = w_entry[g+1];
        end

        stid_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (w_valid[g]),
            .i_found       (w_found),
            .i_left_entry  (w_left_entry[g]),
            .i_left_le     (w_left_le[g]),
            .i_left_lt     (w_left_lt[g]),
            .i_right_entry (w_right_entry[g]),
            .o_entry       (w_entry[g]),
            .o_le          (w_le[g]),
            .o_lt          (w_lt[g]),
            .o_hit         (w_hit[g])
        );
    end

    // Count update and result
    always_comb begin
        n_count      = r_count;
        n_rsp.status = STAT_OK;
        n_rsp.found  = 1'b0;
        unique case (i_req.mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_rsp.status = STAT_FULL;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            MODE_DELETE: begin
                if (w_found) begin
                    n_count     = r_count - CNT_BITS'(1);
                    n_rsp.found = 1'b1;
                end else begin
                    n_rsp.status = STAT_NOT_FOUND;
                end
            end
            MODE_LOOKUP: begin
                if (w_found) begin
                    n_rsp.found = 1'b1;
                end else begin
                    n_rsp.status = STAT_NOT_FOUND;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.count = OUT_CNT_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("count above capacity");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("request without result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == STAT_FULL)) |-> (r_count == CNT_BITS'(CAPACITY)))
        else $error("full status with room left");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.found) |-> (o_rsp.status == STAT_OK))
        else $error("found with bad status");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_table_insert_delete. A short table of
// directed requests covers empty and full tables, extreme keys, duplicates
// and every mode. Random requests follow, biased toward keys already held so
// that deletes and lookups hit. Each result is checked against the bench's
// sorted-table model, or against a hand-typed value where a row gives one.
// ----------------------------------------------------------------------------

module tb_top;
    import stid_pkg::*;

    localparam int RANDOM_REQUESTS = 900;
    localparam int DRAIN_CYCLES    = 4;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    // Directed stimulus: a row repeats reps times with the value stepped by one
    typedef struct {
        t_mode             mode;
        logic signed [31:0] value;
        int                reps;
        bit                typed;
        t_status           status;
        bit                found;
        int                count;
    } t_dir_row;

    t_dir_row dir_rows [13] = '{
        '{MODE_LOOKUP, 32'sd0,      1,  1'b1, STAT_NOT_FOUND, 1'b0, 0},
        '{MODE_DELETE, 32'sd5,      1,  1'b1, STAT_NOT_FOUND, 1'b0, 0},
        '{MODE_INSERT, KEY_MAX,     1,  1'b1, STAT_OK,        1'b0, 1},
        '{MODE_INSERT, KEY_MIN,     1,  1'b1, STAT_OK,        1'b0, 2},
        '{MODE_INSERT, KEY_MAX,     1,  1'b0, STAT_OK,        1'b0, 0},  // equal to tail
        '{MODE_INSERT, 32'sd0,      1,  1'b0, STAT_OK,        1'b0, 0},
        '{MODE_LOOKUP, KEY_MIN,     1,  1'b0, STAT_OK,        1'b0, 0},
        '{MODE_LOOKUP, -32'sd1,     1,  1'b0, STAT_OK,        1'b0, 0},
        '{MODE_DELETE, KEY_MAX,     1,  1'b0, STAT_OK,        1'b0, 0},
        '{MODE_DELETE, 32'sd12345,  1,  1'b0, STAT_OK,        1'b0, 0},
        '{MODE_INSERT, -32'sd6,     13, 1'b0, STAT_OK,        1'b0, 0},  // fills table
        '{MODE_INSERT, 32'sd7,      1,  1'b1, STAT_FULL,      1'b0, 16},
        '{MODE_CLEAR,  32'sd0,      1,  1'b1, STAT_OK,        1'b0, 0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    // Hand-typed expectation travels with the request it belongs to
    logic req_typed     = 1'b0;
    t_rsp req_typed_rsp = '0;

    // Model of the table contents
    t_key held_keys [CAPACITY];
    int   held_count = 0;

    t_rsp pending_rsp [$];
    int   error_count = 0;

    // Coverage tallies
    int   mode_tally [4] = '{0, 0, 0, 0};
    int   full_drops = 0;
    int   misses     = 0;
    int   hits       = 0;
    int   peak_fill  = 0;

    sorted_table_insert_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Apply one request to the table model and return its result
    function automatic t_rsp apply_table_op(input t_req req);
        t_key key;
        int   pos;
        int   i;
        t_rsp rsp;
        key        = t_key'(req.value);
        rsp.status = STAT_OK;
        rsp.found  = 1'b0;
        case (req.mode)
            MODE_INSERT: begin
                if (held_count >= CAPACITY) begin
                    rsp.status = STAT_FULL;
                end else begin
                    // new key lands after every equal key
                    pos = 0;
                    while (pos < held_count && held_keys[pos] <= key)
                        pos++;
                    for (i = held_count; i > pos; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[pos] = key;
                    held_count++;
                end
            end
            MODE_DELETE, MODE_LOOKUP: begin
                pos = held_count;
                for (i = 0; i < held_count && pos == held_count; i++)
                    if (held_keys[i] == key)
                        pos = i;
                if (pos == held_count) begin
                    rsp.status = STAT_NOT_FOUND;
                end else begin
                    rsp.found = 1'b1;
                    if (req.mode == MODE_DELETE) begin
                        for (i = pos; i + 1 < held_count; i++)
                            held_keys[i] = held_keys[i+1];
                        held_count--;
                    end
                end
            end
            default: held_count = 0;
        endcase
        rsp.count = OUT_CNT_BITS'(held_count);
        return rsp;
    endfunction

    // Random key: a small cluster, extremes, a held key so hits occur, or a full-range value
    function automatic logic signed [31:0] pick_key(input bit prefer_held);
        int sel;
        sel = $urandom_range(9);
        if (prefer_held && held_count > 0 && sel < 5)
            return held_keys[$urandom_range(held_count - 1)];
        case (sel)
            0, 1, 2: return $signed($urandom_range(8)) - 32'sd4;
            3: begin
                case ($urandom_range(3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    // Result check and model update, both on the same sampling edge
    always @(posedge i_clk) begin : result_monitor
        t_rsp want;
        t_rsp model_rsp;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_rsp.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                        error_count++;
                    end
                    if (o_rsp.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, o_rsp.found);
                        error_count++;
                    end
                    if (o_rsp.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_rsp.count);
                        error_count++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                model_rsp = apply_table_op(i_req);
                pending_rsp.push_back(req_typed ? req_typed_rsp : model_rsp);
                mode_tally[i_req.mode]++;
                if (model_rsp.status == STAT_FULL)
                    full_drops++;
                if (model_rsp.status == STAT_NOT_FOUND)
                    misses++;
                if (model_rsp.found)
                    hits++;
                if (held_count > peak_fill)
                    peak_fill = held_count;
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(input t_mode mode, input logic signed [31:0] value,
                                input bit typed, input t_rsp typed_rsp, input bit may_idle);
        while (may_idle && $urandom_range(99) < 11) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_req.mode    <= mode;
        i_req.value   <= value;
        req_typed     <= typed;
        req_typed_rsp <= typed_rsp;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    // Stop issuing and wait for every outstanding result
    task automatic wait_for_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // Main sequence
    initial begin : stimulus
        t_rsp  typed_rsp;
        t_mode mode;
        int    pick;
        bit    may_idle;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            typed_rsp.status = dir_rows[r].status;
            typed_rsp.found  = dir_rows[r].found;
            typed_rsp.count  = OUT_CNT_BITS'(dir_rows[r].count);
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_request(dir_rows[r].mode, dir_rows[r].value + k,
                             dir_rows[r].typed, typed_rsp, 1'b1);
        end

        // random traffic, inserts outweigh deletes so the table fills often
        typed_rsp = '0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(99);
            if (pick < 48)
                mode = MODE_INSERT;
            else if (pick < 72)
                mode = MODE_DELETE;
            else if (pick < 97)
                mode = MODE_LOOKUP;
            else
                mode = MODE_CLEAR;
            // back-to-back stretch in the middle of the run
            may_idle = (n < 300 || n >= 500);
            if (n == 600)
                wait_for_results();
            send_request(mode, pick_key(mode != MODE_INSERT), 1'b0, typed_rsp, may_idle);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests: %0d insert, %0d delete, %0d lookup, %0d clear",
                 mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
                 mode_tally[MODE_INSERT], mode_tally[MODE_DELETE],
                 mode_tally[MODE_LOOKUP], mode_tally[MODE_CLEAR]);
        $display("%0d dropped on full table, %0d misses, %0d hits, peak fill %0d of %0d",
                 full_drops, misses, hits, peak_fill, CAPACITY);
        if (error_count == 0)
            $display("sorted_table_insert_delete verification clean");
        else
            $display("sorted_table_insert_delete verification failed");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("sorted_table_insert_delete verification failed");
        $finish;
    end

endmodule
